/* hdl/three_stack_overflow_placer_defines.svh */
`ifndef THREE_STACK_OVERFLOW_PLACER_DEFINES_SVH
`define THREE_STACK_OVERFLOW_PLACER_DEFINES_SVH

// concurrent check, off while reset is low
`define TSOP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// concurrent check that also holds during reset
`define TSOP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

/* hdl/tsop_pkg.sv */
package tsop_pkg;

	localparam int DATA_W     = 32;
	localparam int FILL_W     = 5;
	localparam int SEL_W      = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int NUM_STACKS = 3;
	localparam int S_TDATA_W  = 40;
	localparam int S_TUSER_W  = 1;
	localparam int M_TDATA_W  = 40;
	localparam int M_TUSER_W  = 2;

	typedef logic [STAT_W-1:0]    status_t;
	typedef logic [SEL_W-1:0]     sel_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [FILL_W-1:0]    fill_t;

	localparam status_t STAT_STORED   = 2'd0;
	localparam status_t STAT_REJECTED = 2'd1;
	localparam status_t STAT_POPPED   = 2'd2;
	localparam status_t STAT_EMPTY    = 2'd3;

	localparam sel_t STK_FIRST  = 2'd0;
	localparam sel_t STK_SECOND = 2'd1;
	localparam sel_t STK_THIRD  = 2'd2;

	localparam cfg_idx_t CFG_CAP_FIRST  = 2'd0;
	localparam cfg_idx_t CFG_CAP_SECOND = 2'd1;
	localparam cfg_idx_t CFG_CAP_THIRD  = 2'd2;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam fill_t CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

/* hdl/tsop_ctrl.sv */
module tsop_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  tsop_pkg::dp_stat_t stat,
	output logic               s_tready,
	output tsop_pkg::dp_cmd_t  cmd
);
	import tsop_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.exec   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

/* hdl/tsop_stack_mem.sv */
module tsop_stack_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [AW-1:0]               addr,
	input  logic [tsop_pkg::DATA_W-1:0] wdata,
	output logic [tsop_pkg::DATA_W-1:0] rdata
);
	import tsop_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		if (re) rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/tsop_dp.sv */
module tsop_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsop_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsop_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_kind,
	input  logic [tsop_pkg::DATA_W-1:0]    in_value,
	input  logic [tsop_pkg::SEL_W-1:0]     in_sel,
	input  tsop_pkg::dp_cmd_t              cmd,
	output tsop_pkg::dp_stat_t             stat,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tsop_pkg::STAT_W-1:0]    out_status,
	output logic [tsop_pkg::SEL_W-1:0]     out_used,
	output logic [tsop_pkg::DATA_W-1:0]    out_popped,
	output logic [tsop_pkg::FILL_W-1:0]    out_fill
);
	import tsop_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	fill_t             cap_q [NUM_STACKS];
	fill_t             cnt_q [NUM_STACKS];
	logic              full [NUM_STACKS];
	logic [DATA_W-1:0] rdata [NUM_STACKS];

	logic              kind_q;
	logic [DATA_W-1:0] value_q;
	sel_t              sel_q;

	sel_t              tgt;
	logic              hit;
	status_t           status;
	fill_t             cnt_tgt;
	fill_t             fill_new;
	logic [AW-1:0]     addr;

	status_t           res_status_q;
	sel_t              res_used_q;
	fill_t             res_fill_q;
	logic              res_pop_q;
	sel_t              res_tgt_q;

	logic              m_tvalid_q;
	status_t           out_status_q;
	sel_t              out_used_q;
	logic [DATA_W-1:0] out_popped_q;
	fill_t             out_fill_q;

	// capacity registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) cap_q[i] <= CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAP_FIRST:  cap_q[0] <= cfg_data;
				CFG_CAP_SECOND: cap_q[1] <= cfg_data;
				CFG_CAP_THIRD:  cap_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			value_q <= in_value;
			sel_q   <= in_sel;
		end
	end

	// capacity above depth acts as depth
	always_comb begin
		for (int i = 0; i < NUM_STACKS; i++) begin
			if (int'(cap_q[i]) > STACK_DEPTH) begin
				full[i] = int'(cnt_q[i]) >= STACK_DEPTH;
			end else begin
				full[i] = cnt_q[i] >= cap_q[i];
			end
		end
	end

	// placement order: third, first, second
	always_comb begin
		tgt    = STK_FIRST;
		hit    = 1'b0;
		status = STAT_REJECTED;
		if (kind_q == KIND_PUSH) begin
			if (!full[2]) begin
				tgt = STK_THIRD;
				hit = 1'b1;
			end else if (!full[0]) begin
				tgt = STK_FIRST;
				hit = 1'b1;
			end else if (!full[1]) begin
				tgt = STK_SECOND;
				hit = 1'b1;
			end
			status = hit ? STAT_STORED : STAT_REJECTED;
		end else begin
			status = STAT_EMPTY;
			if (int'(sel_q) < NUM_STACKS) begin
				tgt = sel_q;
				hit = cnt_q[sel_q] != '0;
				status = hit ? STAT_POPPED : STAT_EMPTY;
			end
		end
	end

	assign cnt_tgt  = cnt_q[tgt];
	assign fill_new = (kind_q == KIND_PUSH) ? cnt_tgt + 1'b1 : cnt_tgt - 1'b1;
	assign addr     = (kind_q == KIND_PUSH) ? AW'(cnt_tgt) : AW'(fill_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) cnt_q[i] <= '0;
		end else if (cmd.exec && hit) begin
			cnt_q[tgt] <= fill_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= status;
			res_used_q   <= tgt;
			res_fill_q   <= hit ? fill_new : '0;
			res_pop_q    <= hit && (kind_q == KIND_POP);
			res_tgt_q    <= tgt;
		end
	end

	for (genvar g = 0; g < NUM_STACKS; g++) begin : g_stack
		logic sel_here;
		assign sel_here = cmd.exec && hit && (tgt == SEL_W'(g));
		tsop_stack_mem #(
			.DEPTH(STACK_DEPTH),
			.AW   (AW)
		) u_mem (
			.clk  (clk),
			.we   (sel_here && (kind_q == KIND_PUSH)),
			.re   (sel_here && (kind_q == KIND_POP)),
			.addr (addr),
			.wdata(value_q),
			.rdata(rdata[g])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status_q <= res_status_q;
			out_used_q   <= res_used_q;
			out_fill_q   <= res_fill_q;
			out_popped_q <= res_pop_q ? rdata[res_tgt_q] : '0;
		end
	end

	assign stat.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid      = m_tvalid_q;
	assign out_status    = out_status_q;
	assign out_used      = out_used_q;
	assign out_popped    = out_popped_q;
	assign out_fill      = out_fill_q;

endmodule

/* hdl/three_stack_overflow_placer.sv */
// bank of three lifo stacks with overflow placement
// input stream (s_*): one transaction per item; s_tuser is the kind (push or pop),
//   s_tdata carries the push value and the stack to pop
// output stream (m_*): exactly one result transaction per input item, in order;
//   m_tuser is the status, m_tdata carries stack used, popped value and fill after
// a push goes to stack three, else stack one, else stack two; all full rejects it
// config port: cfg_we writes cfg_data into capacity register cfg_index
//   (0 first, 1 second, 2 third); the user must write only while the block is idle,
//   which the block itself does not enforce
// a result passes the input, result and output registers before m_tvalid rises
// the controller takes one item at a time, through accept, stack memory access with
//   registered read, and result register load; the next item is accepted while a
//   result waits in the output register; if the receiver stalls, the following result
//   holds in the datapath and s_tready stays low until the output register frees
// reset: counts cleared, all capacities 16, stack contents undefined (no clearing
//   pass, entries are read only after being written), output stream empty
module three_stack_overflow_placer #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsop_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsop_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tsop_pkg::S_TDATA_W-1:0] s_tdata,   // push_value, pop_stack, zero pad
	input  logic [tsop_pkg::S_TUSER_W-1:0] s_tuser,   // kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tsop_pkg::M_TDATA_W-1:0] m_tdata,   // stack_used, popped_value, fill_after, pad
	output logic [tsop_pkg::M_TUSER_W-1:0] m_tuser    // status
);
	import tsop_pkg::*;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	status_t           out_status;
	sel_t              out_used;
	logic [DATA_W-1:0] out_popped;
	fill_t             out_fill;

	tsop_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.stat    (stat),
		.s_tready(s_tready),
		.cmd     (cmd)
	);

	tsop_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (s_tuser[0]),
		.in_value  (s_tdata[DATA_W-1:0]),
		.in_sel    (s_tdata[DATA_W+SEL_W-1:DATA_W]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_status(out_status),
		.out_used  (out_used),
		.out_popped(out_popped),
		.out_fill  (out_fill)
	);

	assign m_tdata = {{(M_TDATA_W-SEL_W-DATA_W-FILL_W){1'b0}}, out_fill, out_popped, out_used};
	assign m_tuser = out_status;

endmodule

/* hdl/tsop_checker.sv */
`include "three_stack_overflow_placer_defines.svh"

module tsop_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tsop_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [tsop_pkg::M_TUSER_W-1:0] m_tuser
);
	import tsop_pkg::*;

	`TSOP_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !m_tvalid, "result valid during reset")
	`TSOP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`TSOP_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second item accepted while busy")
	`TSOP_ASSERT(a_value_zero, m_tvalid && m_tuser != STAT_POPPED |-> m_tdata[33:2] == '0, "value without successful pop")
	`TSOP_ASSERT(a_reject_clean, m_tvalid && m_tuser == STAT_REJECTED |-> m_tdata[1:0] == '0 && m_tdata[38:34] == '0, "rejected push reports a stack")

endmodule

bind three_stack_overflow_placer tsop_checker u_tsop_checker (.*);

/* dv/three_stack_overflow_placer_tb.sv */
`timescale 1ns / 100ps

module three_stack_overflow_placer_tb;
	import tsop_pkg::*;

	localparam int   STACK_DEPTH = 16;
	localparam int   STALL_LIMIT = 5000;
	localparam int   PHASES      = 8;
	localparam int   PHASE_ITEMS = 66;
	localparam sel_t STK_NONE    = 2'd3;

	typedef struct packed {
		status_t           status;
		sel_t              used;
		logic [DATA_W-1:0] popped;
		fill_t             fill;
	} result_t;

	typedef struct {
		bit                is_cfg;
		cfg_idx_t          idx;
		logic [CFG_W-1:0]  cap;
		logic              kind;
		logic [DATA_W-1:0] val;
		sel_t              sel;
		bit                typed;
		result_t           res;
	} row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [S_TUSER_W-1:0] s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	logic [CFG_W-1:0]  capacity [NUM_STACKS];
	int                stack_fill [NUM_STACKS];
	logic [DATA_W-1:0] stack_words [NUM_STACKS][STACK_DEPTH];
	result_t           pending_results [$];
	row_t              script [$];
	bit                cur_typed = 1'b0;
	result_t           cur_res   = '0;
	bit                no_idle   = 1'b0;
	int                mismatches = 0;
	int                stall_cycles = 0;

	three_stack_overflow_placer #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // push_value, pop_stack, zero pad
		.s_tuser  (s_tuser),   // kind
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // stack_used, popped_value, fill_after, pad
		.m_tuser  (m_tuser)    // status
	);

	always #6 clk = ~clk;

	function automatic result_t place_or_pop(logic kind, logic [DATA_W-1:0] val, sel_t sel);
		sel_t    order [3];
		result_t r;
		int      s;
		int      lim;
		bit      placed;
		order  = '{STK_THIRD, STK_FIRST, STK_SECOND};
		r      = '{STAT_REJECTED, STK_FIRST, '0, '0};
		placed = 1'b0;
		if (kind == KIND_PUSH) begin
			for (int i = 0; i < 3; i++) begin
				s   = order[i];
				lim = (capacity[s] > STACK_DEPTH) ? STACK_DEPTH : capacity[s];
				if (!placed && stack_fill[s] < lim) begin
					stack_words[s][stack_fill[s]] = val;
					stack_fill[s]++;
					r.status = STAT_STORED;
					r.used   = sel_t'(s);
					r.fill   = fill_t'(stack_fill[s]);
					placed   = 1'b1;
				end
			end
		end else begin
			r.status = STAT_EMPTY;
			if (sel != STK_NONE) begin
				r.used = sel;
				if (stack_fill[sel] > 0) begin
					stack_fill[sel]--;
					r.popped = stack_words[sel][stack_fill[sel]];
					r.status = STAT_POPPED;
					r.fill   = fill_t'(stack_fill[sel]);
				end
			end
		end
		return r;
	endfunction

	function automatic row_t row_op(logic kind, logic [DATA_W-1:0] val, sel_t sel);
		row_t r;
		r        = '{default: '0};
		r.kind   = kind;
		r.val    = val;
		r.sel    = sel;
		return r;
	endfunction

	function automatic row_t row_chk(logic kind, logic [DATA_W-1:0] val, sel_t sel,
			status_t status, sel_t used, logic [DATA_W-1:0] popped, fill_t fill);
		row_t r;
		r       = row_op(kind, val, sel);
		r.typed = 1'b1;
		r.res   = '{status, used, popped, fill};
		return r;
	endfunction

	function automatic row_t row_cfg(cfg_idx_t idx, logic [CFG_W-1:0] cap);
		row_t r;
		r        = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.cap    = cap;
		return r;
	endfunction

	// transaction monitor and scoreboard
	always @(posedge clk) begin
		result_t got;
		result_t want;
		result_t pred;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pred = place_or_pop(s_tuser[0], s_tdata[31:0], s_tdata[33:32]);
				pending_results.push_back(cur_typed ? cur_res : pred);
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[1:0], m_tdata[33:2], m_tdata[38:34]};
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result status=%0d used=%0d popped=%h fill=%0d",
							got.status, got.used, got.popped, got.fill);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.used !== want.used ||
							got.popped !== want.popped || got.fill !== want.fill) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp status=%0d used=%0d popped=%h fill=%0d, got status=%0d used=%0d popped=%h fill=%0d",
								want.status, want.used, want.popped, want.fill,
								got.status, got.used, got.popped, got.fill);
					end
				end
			end
		end
	end

	always @(negedge clk)
		m_tready <= no_idle || ($urandom_range(99) >= 34);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(cfg_idx_t idx, logic [CFG_W-1:0] cap);
		drain_results();
		@(negedge clk);
		cfg_we        <= 1'b1;
		cfg_index     <= idx;
		cfg_data      <= cap;
		capacity[idx]  = cap;
		@(negedge clk);
		cfg_we        <= 1'b0;
	endtask

	task automatic send_item(logic kind, logic [DATA_W-1:0] val, sel_t sel, bit typed,
			result_t res);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= {6'd0, sel, val};
		s_tuser   <= kind;
		cur_typed <= typed;
		cur_res   <= res;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		logic [CFG_W-1:0] phase_caps [PHASES][NUM_STACKS];
		logic             kind;
		sel_t             sel;
		int               push_bias;
		phase_caps = '{'{16, 16, 16}, '{2, 3, 1}, '{0, 0, 31}, '{0, 0, 0},
			'{0, 0, 0}, '{16, 5, 0}, '{0, 0, 0}, '{16, 16, 16}};
		for (int s = 0; s < NUM_STACKS; s++) begin
			capacity[s]   = CAP_RESET;
			stack_fill[s] = 0;
		end

		// empty pops, bad selector, value extremes on stack three
		script.push_back(row_chk(KIND_POP, '0, STK_FIRST, STAT_EMPTY, STK_FIRST, '0, '0));
		script.push_back(row_chk(KIND_POP, '0, STK_SECOND, STAT_EMPTY, STK_SECOND, '0, '0));
		script.push_back(row_chk(KIND_POP, '0, STK_THIRD, STAT_EMPTY, STK_THIRD, '0, '0));
		script.push_back(row_chk(KIND_POP, '1, STK_NONE, STAT_EMPTY, STK_FIRST, '0, '0));
		script.push_back(row_chk(KIND_PUSH, 32'h7fffffff, STK_FIRST, STAT_STORED, STK_THIRD,
			'0, 5'd1));
		script.push_back(row_chk(KIND_PUSH, 32'h80000000, STK_FIRST, STAT_STORED, STK_THIRD,
			'0, 5'd2));
		script.push_back(row_chk(KIND_POP, '0, STK_THIRD, STAT_POPPED, STK_THIRD,
			32'h80000000, 5'd1));
		script.push_back(row_chk(KIND_POP, '0, STK_THIRD, STAT_POPPED, STK_THIRD,
			32'h7fffffff, 5'd0));
		script.push_back(row_chk(KIND_PUSH, 32'hffffffff, STK_NONE, STAT_STORED, STK_THIRD,
			'0, 5'd1));
		script.push_back(row_chk(KIND_PUSH, 32'h0, STK_NONE, STAT_STORED, STK_THIRD,
			'0, 5'd2));
		script.push_back(row_chk(KIND_POP, '0, STK_THIRD, STAT_POPPED, STK_THIRD,
			32'h0, 5'd1));
		script.push_back(row_chk(KIND_POP, '0, STK_THIRD, STAT_POPPED, STK_THIRD,
			32'hffffffff, 5'd0));
		// zero capacity on stack three, overflow into one then two, all full
		script.push_back(row_cfg(CFG_CAP_THIRD, 5'd0));
		script.push_back(row_cfg(CFG_CAP_FIRST, 5'd1));
		script.push_back(row_cfg(CFG_CAP_SECOND, 5'd2));
		script.push_back(row_op(KIND_PUSH, 32'h12345678, STK_NONE));
		script.push_back(row_op(KIND_PUSH, $urandom, STK_SECOND));
		script.push_back(row_op(KIND_PUSH, $urandom, STK_THIRD));
		script.push_back(row_chk(KIND_PUSH, $urandom, STK_FIRST, STAT_REJECTED, STK_FIRST,
			'0, '0));
		// capacity below fill: still full, entries still pop
		script.push_back(row_cfg(CFG_CAP_SECOND, 5'd1));
		script.push_back(row_chk(KIND_PUSH, $urandom, STK_FIRST, STAT_REJECTED, STK_FIRST,
			'0, '0));
		script.push_back(row_op(KIND_POP, $urandom, STK_SECOND));
		script.push_back(row_op(KIND_POP, $urandom, STK_SECOND));
		script.push_back(row_op(KIND_POP, $urandom, STK_FIRST));
		script.push_back(row_chk(KIND_POP, $urandom, STK_FIRST, STAT_EMPTY, STK_FIRST,
			'0, '0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_capacity(script[i].idx, script[i].cap);
			else
				send_item(script[i].kind, script[i].val, script[i].sel, script[i].typed,
					script[i].res);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 4 || p == 6)
				for (int s = 0; s < NUM_STACKS; s++)
					phase_caps[p][s] = CFG_W'($urandom_range(STACK_DEPTH));
			write_capacity(CFG_CAP_FIRST, phase_caps[p][0]);
			write_capacity(CFG_CAP_SECOND, phase_caps[p][1]);
			write_capacity(CFG_CAP_THIRD, phase_caps[p][2]);
			no_idle = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				push_bias = (i < PHASE_ITEMS / 2) ? 75 : 30;
				kind = ($urandom_range(99) < push_bias) ? KIND_PUSH : KIND_POP;
				if (kind == KIND_PUSH || $urandom_range(7) == 0)
					sel = sel_t'($urandom_range(3));
				else
					sel = sel_t'($urandom_range(2));
				send_item(kind, $urandom, sel, 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/tsop_pkg.sv
hdl/tsop_ctrl.sv
hdl/tsop_stack_mem.sv
hdl/tsop_dp.sv
hdl/three_stack_overflow_placer.sv
hdl/tsop_checker.sv
dv/three_stack_overflow_placer_tb.sv
